[rtl/core/wfgdd_pkg.sv]
package wfgdd_pkg;
  localparam int MaxThreads = 16;
  localparam int MaxResources = 16;
  localparam int MaxNodes = 32;
  localparam int CfgWidth = 5;

  localparam logic [1:0] REQ_HOLD = 2'd0;
  localparam logic [1:0] REQ_WAIT = 2'd1;
  localparam logic [1:0] REQ_CHECK = 2'd2;
  localparam logic [1:0] REQ_CLEAR = 2'd3;

  localparam logic CFG_THREADS = 1'b0;
  localparam logic CFG_RESOURCES = 1'b1;

  typedef struct packed {
    logic load;
    logic set_edge;
    logic clear_all;
    logic walk_init;
    logic walk_step;
    logic next_start;
  } cmd_t;

  typedef struct packed {
    logic edge_bad;
    logic walk_done;
    logic walk_cycle;
    logic start_done;
  } stat_t;
endpackage

[rtl/core/wfgdd_ctrl.sv]
module wfgdd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [1:0]        req_type,
  input  wfgdd_pkg::stat_t  stat,
  output wfgdd_pkg::cmd_t   cmd,
  output logic              busy,
  output logic              out_valid,
  output logic              out_deadlock_found,
  output logic              out_status
);
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INIT = 2'd1;
  localparam logic [1:0] S_WALK = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic valid_r, valid_nxt;
  logic found_r, found_nxt;
  logic status_r, status_nxt;
  logic accept;

  assign accept = start && state_r == S_IDLE;
  assign busy = state_r != S_IDLE;

  always_comb begin
    state_nxt = state_r;
    valid_nxt = 1'b0;
    found_nxt = found_r;
    status_nxt = status_r;
    cmd = '0;
    cmd.load = accept;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (req_type == wfgdd_pkg::REQ_CHECK) begin
            state_nxt = S_INIT;
          end else begin
            valid_nxt = 1'b1;
            found_nxt = 1'b0;
            status_nxt = 1'b0;
            if (req_type == wfgdd_pkg::REQ_CLEAR) begin
              cmd.clear_all = 1'b1;
            end else begin
              cmd.set_edge = 1'b1;
            end
          end
        end
      end
      S_INIT: begin
        if (stat.start_done) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
          found_nxt = 1'b0;
          status_nxt = 1'b0;
        end else begin
          cmd.walk_init = 1'b1;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_cycle) begin
          state_nxt = S_IDLE;
          valid_nxt = 1'b1;
          found_nxt = 1'b1;
          status_nxt = 1'b0;
        end else if (stat.walk_done) begin
          cmd.next_start = 1'b1;
          state_nxt = S_INIT;
        end else begin
          cmd.walk_step = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
    end
    found_r <= found_nxt;
    status_r <= (state_r == S_IDLE && accept && req_type != wfgdd_pkg::REQ_CHECK
                 && req_type != wfgdd_pkg::REQ_CLEAR) ? stat.edge_bad : status_nxt;
  end

  assign out_valid = valid_r;
  assign out_deadlock_found = found_r;
  assign out_status = status_r;
endmodule

[rtl/core/wfgdd_dp.sv]
module wfgdd_dp #(
  parameter int MAX_THREADS = wfgdd_pkg::MaxThreads,
  parameter int MAX_RESOURCES = wfgdd_pkg::MaxResources,
  parameter int MAX_NODES = wfgdd_pkg::MaxNodes
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wfgdd_pkg::cmd_t               cmd,
  input  logic [1:0]                    req_type,
  input  logic [3:0]                    thread_index,
  input  logic [3:0]                    resource_index,
  input  logic                          cfg_we,
  input  logic                          cfg_index,
  input  logic [wfgdd_pkg::CfgWidth-1:0] cfg_data,
  output wfgdd_pkg::stat_t              stat
);
  localparam int NW = $clog2(MAX_NODES);
  localparam int CW = wfgdd_pkg::CfgWidth;

  logic [MAX_NODES-1:0] edge_r [MAX_NODES];
  logic [MAX_NODES-1:0] gray_r, black_r;
  logic [NW-1:0] stk_node [MAX_NODES];
  logic [NW:0] stk_next [MAX_NODES];
  logic [NW:0] depth_r;
  logic [NW:0] start_r;
  logic [CW-1:0] nthr_r, nres_r, nthr_c, nres_c;
  logic [MAX_NODES-1:0] in_use;
  logic [NW-1:0] top_idx, top_node, jn;
  logic [NW:0] j;
  logic edge_ok;

  function automatic logic [CW-1:0] clampc(input logic [CW-1:0] v, input int mx);
    logic [CW-1:0] res;
    res = v;
    if (v == '0) res = CW'(1);
    else if (int'(v) > mx) res = CW'(mx);
    return res;
  endfunction

  assign nthr_c = clampc(cfg_data, MAX_THREADS);
  assign nres_c = clampc(cfg_data, MAX_RESOURCES);

  always_comb begin
    for (int n = 0; n < MAX_NODES; n++) begin
      if (n < MAX_THREADS) in_use[n] = n < int'(nthr_r);
      else in_use[n] = (n - MAX_THREADS) < int'(nres_r);
    end
  end

  assign edge_ok = int'(thread_index) < int'(nthr_r) && int'(resource_index) < int'(nres_r)
                   && (MAX_THREADS + int'(resource_index)) < MAX_NODES;

  assign top_idx = NW'(depth_r - 1'b1);
  assign top_node = stk_node[top_idx];
  assign j = stk_next[top_idx];
  assign jn = j[NW-1:0];

  always_comb begin
    stat.edge_bad = !edge_ok;
    stat.start_done = start_r == (NW+1)'(MAX_NODES);
    stat.walk_done = depth_r == '0;
    stat.walk_cycle = depth_r != '0 && j < (NW+1)'(MAX_NODES) && in_use[jn]
                      && edge_r[top_node][jn] && gray_r[jn];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nthr_r <= CW'(MAX_THREADS);
      nres_r <= CW'(MAX_RESOURCES);
      depth_r <= '0;
      start_r <= '0;
      for (int n = 0; n < MAX_NODES; n++) edge_r[n] <= '0;
    end else begin
      if (cfg_we && cfg_index == wfgdd_pkg::CFG_THREADS) nthr_r <= nthr_c;
      if (cfg_we && cfg_index == wfgdd_pkg::CFG_RESOURCES) nres_r <= nres_c;
      if (cmd.clear_all) begin
        for (int n = 0; n < MAX_NODES; n++) edge_r[n] <= '0;
      end
      if (cmd.set_edge && edge_ok) begin
        if (req_type == wfgdd_pkg::REQ_HOLD)
          edge_r[NW'(MAX_THREADS + int'(resource_index))][NW'(thread_index)] <= 1'b1;
        else
          edge_r[NW'(thread_index)][NW'(MAX_THREADS + int'(resource_index))] <= 1'b1;
      end
      if (cmd.load) start_r <= '0;
      if (cmd.next_start) start_r <= start_r + 1'b1;
      if (cmd.walk_init) begin
        if (in_use[NW'(start_r)]) begin
          gray_r <= MAX_NODES'(1) << NW'(start_r);
          black_r <= '0;
          stk_node[0] <= NW'(start_r);
          stk_next[0] <= '0;
          depth_r <= (NW+1)'(1);
        end else begin
          depth_r <= '0;
        end
      end
      if (cmd.walk_step && depth_r != '0) begin
        if (j >= (NW+1)'(MAX_NODES)) begin
          gray_r[top_node] <= 1'b0;
          black_r[top_node] <= 1'b1;
          depth_r <= depth_r - 1'b1;
        end else begin
          stk_next[top_idx] <= j + 1'b1;
          if (in_use[jn] && edge_r[top_node][jn] && !gray_r[jn] && !black_r[jn]
              && depth_r < (NW+1)'(MAX_NODES)) begin
            gray_r[jn] <= 1'b1;
            stk_node[NW'(depth_r)] <= jn;
            stk_next[NW'(depth_r)] <= '0;
            depth_r <= depth_r + 1'b1;
          end
        end
      end
    end
  end
endmodule

[rtl/core/wait_for_graph_deadlock_detector.sv]
// Wait-for graph deadlock detector.
// An item is taken at a clock edge where start is high and busy is low.
// Request 0 sets resource-to-thread, 1 sets thread-to-resource, 2 checks
// the graph for a cycle, 3 clears the whole graph.
// Edge and clear items give their result in the cycle after acceptance, and
// busy stays low, so one such item may be given every cycle.
// A check walks depth-first from every node in turn, one edge test per
// cycle, and busy stays high until its result appears.
// Each result appears for exactly one cycle with out_valid high; the
// receiver cannot stall it.
// Configuration writes through cfg_we take effect at once and must be
// made only while idle.
// Reset clears the graph and sets both node counts to their maximum.
module wait_for_graph_deadlock_detector #(
  parameter int MAX_THREADS = wfgdd_pkg::MaxThreads,
  parameter int MAX_RESOURCES = wfgdd_pkg::MaxResources,
  parameter int MAX_NODES = wfgdd_pkg::MaxNodes
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_req_type,
  input  logic [3:0]                     in_thread_index,
  input  logic [3:0]                     in_resource_index,
  output logic                           out_valid,
  output logic                           out_deadlock_found,
  output logic                           out_status,
  input  logic                           cfg_we,
  input  logic                           cfg_index,
  input  logic [wfgdd_pkg::CfgWidth-1:0] cfg_data
);
  wfgdd_pkg::cmd_t cmd;
  wfgdd_pkg::stat_t stat;

  wfgdd_ctrl u_ctrl (
    .clk, .rst_n, .start, .req_type(in_req_type), .stat, .cmd, .busy,
    .out_valid, .out_deadlock_found, .out_status
  );

  wfgdd_dp #(
    .MAX_THREADS(MAX_THREADS), .MAX_RESOURCES(MAX_RESOURCES), .MAX_NODES(MAX_NODES)
  ) u_dp (
    .clk, .rst_n, .cmd, .req_type(in_req_type), .thread_index(in_thread_index),
    .resource_index(in_resource_index), .cfg_we, .cfg_index, .cfg_data, .stat
  );

  a_edge_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_req_type != wfgdd_pkg::REQ_CHECK) |=> out_valid)
    else $error("edge item gave no result");
  a_busy_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && !$past(busy)) |-> !out_valid)
    else $error("result while check starting");
  a_found_only_check: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status) |-> !out_deadlock_found)
    else $error("bad result fields");
endmodule
